@@ hdl/dstp_pkg.sv @@
// ----------------------------------------------------------------------------
// Distance softmax package
// Shared sizes, item types, controller commands and the fixed root table.
// ----------------------------------------------------------------------------
package dstp_pkg;

  // Configuration sizes.
  localparam int TOPICS    = 16;
  localparam int DIMS      = 2;
  localparam int KW        = (TOPICS > 1) ? $clog2(TOPICS) : 1;
  localparam int LOC_DEPTH = TOPICS * DIMS;
  localparam int LOC_AW    = (LOC_DEPTH > 1) ? $clog2(LOC_DEPTH) : 1;

  // Fixed-point constants.
  localparam int FRAC_BITS = 16;
  localparam logic [15:0] HALF_LOG2E_Q16 = 16'd47274;
  localparam int QW        = 17;
  localparam int TERM_W    = 33;
  localparam int TOTAL_W   = TERM_W + KW;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DOC  = 1'b1;

  typedef struct packed {
    logic              command;
    logic [3:0]        topic;
    logic [0:0]        dim;
    logic signed [15:0] coord;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [3:0]  topic_out;
    logic [15:0] prob;
    logic        last_out;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic          load_wr;
    logic          capture;
    logic          acc_rd;
    logic          acc_sq;
    logic          acc_add;
    logic          min_step;
    logic          exp_mul;
    logic          exp_step;
    logic          exp_sh;
    logic          div_init;
    logic          div_step;
    logic          div_out;
    logic          clear;
    logic [KW-1:0] k;
    logic [4:0]    step;
  } dstp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dim_ok;
    logic last_doc;
  } dstp_sts_t;

  typedef logic [31:0] root_arr_t [FRAC_BITS];

  // Floor square root of a 64-bit value, used only for the constant table.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    for (int j = 0; j < 32; j++) begin
      b = 64'd1 << (62 - 2 * j);
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // Roots of two: entry i approximates 2^32 * 2^-(2^-(i+1)).
  function automatic root_arr_t calc_roots();
    root_arr_t   tab;
    logic [63:0] r;
    r = floor_sqrt(64'd1 << 63);
    tab[0] = r[31:0];
    for (int i = 1; i < FRAC_BITS; i++) begin
      r = floor_sqrt(r << 32);
      tab[i] = r[31:0];
    end
    return tab;
  endfunction

  localparam root_arr_t ROOTS = calc_roots();

endpackage

@@ hdl/distance_softmax_topic_probs_core.sv @@
// ----------------------------------------------------------------------------
// Distance softmax topic probabilities
// Squared-distance accumulation per topic and a softmax over -d/2.
// ----------------------------------------------------------------------------
// A load item is written to the location memory; busy stays low.
// A document coordinate passes, topic by topic, through the location
// memory read, the squarer and the saturating adder.
// A last coordinate adds a minimum search over the sums, then per topic the
// exponential unit and the serial divider; results come out one per topic
// and cannot be stalled.
// Synchronous reset clears control and the distance sums; locations are kept.
module distance_softmax_topic_probs_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dstp_pkg::item_t   item,
  output logic              busy,
  output logic              strobe,
  output dstp_pkg::result_t result
);
  import dstp_pkg::*;

  dstp_cmd_t cmd;
  dstp_sts_t sts;

  // Controller.
  dstp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath.
  dstp_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .strobe (strobe),
    .result (result)
  );

endmodule

@@ hdl/dstp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Distance softmax controller
// Sequences location loads, accumulation, minimum search, exponentials and division.
// ----------------------------------------------------------------------------
module dstp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  dstp_pkg::item_t    item,
  input  dstp_pkg::dstp_sts_t sts,
  output logic               busy,
  output dstp_pkg::dstp_cmd_t cmd
);
  import dstp_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_ACC_RD   = 11'b00000000010,
    S_ACC_SQ   = 11'b00000000100,
    S_ACC_ADD  = 11'b00000001000,
    S_MIN      = 11'b00000010000,
    S_EXP_MUL  = 11'b00000100000,
    S_EXP_STEP = 11'b00001000000,
    S_EXP_SH   = 11'b00010000000,
    S_DIV_INIT = 11'b00100000000,
    S_DIV_STEP = 11'b01000000000,
    S_DIV_OUT  = 11'b10000000000
  } state_t;

  localparam logic [KW-1:0] K_LAST = KW'(TOPICS - 1);

  state_t        state, state_next;
  logic [KW-1:0] k, k_next;
  logic [4:0]    step, step_next;
  logic          accept;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    k_next     = k;
    step_next  = step;
    cmd        = '0;
    cmd.k      = k;
    cmd.step   = step;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.command == CMD_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            k_next      = '0;
            state_next  = S_ACC_RD;
          end
        end
      end
      S_ACC_RD: begin
        if (sts.dim_ok) begin
          cmd.acc_rd = 1'b1;
          state_next = S_ACC_SQ;
        end else begin
          k_next     = '0;
          state_next = sts.last_doc ? S_MIN : S_IDLE;
        end
      end
      S_ACC_SQ: begin
        cmd.acc_sq = 1'b1;
        state_next = S_ACC_ADD;
      end
      S_ACC_ADD: begin
        cmd.acc_add = 1'b1;
        if (k == K_LAST) begin
          k_next     = '0;
          state_next = sts.last_doc ? S_MIN : S_IDLE;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_ACC_RD;
        end
      end
      S_MIN: begin
        cmd.min_step = 1'b1;
        if (k == K_LAST) begin
          k_next     = '0;
          state_next = S_EXP_MUL;
        end else begin
          k_next = k + 1'b1;
        end
      end
      S_EXP_MUL: begin
        cmd.exp_mul = 1'b1;
        step_next   = '0;
        state_next  = S_EXP_STEP;
      end
      S_EXP_STEP: begin
        cmd.exp_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == 5'(FRAC_BITS - 1)) begin
          state_next = S_EXP_SH;
        end
      end
      S_EXP_SH: begin
        cmd.exp_sh = 1'b1;
        if (k == K_LAST) begin
          k_next     = '0;
          state_next = S_DIV_INIT;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_EXP_MUL;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        step_next    = '0;
        state_next   = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == 5'(QW - 1)) begin
          state_next = S_DIV_OUT;
        end
      end
      S_DIV_OUT: begin
        cmd.div_out = 1'b1;
        if (k == K_LAST) begin
          cmd.clear  = 1'b1;
          k_next     = '0;
          state_next = S_IDLE;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_DIV_INIT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      step  <= step_next;
    end
  end

endmodule

@@ hdl/dstp_dp.sv @@
// ----------------------------------------------------------------------------
// Distance softmax datapath
// Location memory, distance sums, exponential unit and serial divider.
// ----------------------------------------------------------------------------
module dstp_dp (
  input  logic                clk,
  input  logic                rst,
  input  dstp_pkg::item_t     item,
  input  dstp_pkg::dstp_cmd_t cmd,
  output dstp_pkg::dstp_sts_t sts,
  output logic                strobe,
  output dstp_pkg::result_t   result
);
  import dstp_pkg::*;

  logic [15:0]         loc_mem [LOC_DEPTH];
  logic [15:0]         loc_q;
  logic signed [15:0]  coord_q;
  logic [0:0]          dim_q;
  logic                last_q;
  logic [31:0]         sums [TOPICS];
  logic [33:0]         sq;
  logic [31:0]         dmin;
  logic [31:0]         y;
  logic [TERM_W-1:0]   t;
  logic [TERM_W-1:0]   terms [TOPICS];
  logic [TOTAL_W-1:0]  total;
  logic [QW-1:0]       num_lo;
  logic [TOTAL_W:0]    rem;
  logic [QW-1:0]       quo;

  logic [LOC_AW-1:0]   wr_addr;
  logic [LOC_AW-1:0]   rd_addr;
  logic signed [16:0]  diff;
  logic [16:0]         mag;
  logic [34:0]         acc_sum;
  logic [31:0]         gap;
  logic [47:0]         y_full;
  logic [64:0]         t_prod;
  logic [TERM_W-1:0]   t_shifted;
  logic [48:0]         num;
  logic [TOTAL_W:0]    rem_sh;

  assign wr_addr = LOC_AW'(32'(item.topic) * DIMS + 32'(item.dim));
  assign rd_addr = LOC_AW'(32'(cmd.k) * DIMS + 32'(dim_q));

  assign sts.dim_ok   = (32'(dim_q) < DIMS);
  assign sts.last_doc = last_q;

  // Topic location memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.load_wr && (32'(item.topic) < TOPICS) && (32'(item.dim) < DIMS)) begin
      loc_mem[wr_addr] <= item.coord;
    end
    if (cmd.acc_rd) begin
      loc_q <= loc_mem[rd_addr];
    end
  end

  // Document item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      coord_q <= item.coord;
      dim_q   <= item.dim;
      last_q  <= item.last;
    end
  end

  // Squared difference, then saturating accumulate.
  assign diff    = 17'(coord_q) - 17'(signed'(loc_q));
  assign mag     = diff[16] ? 17'(-diff) : 17'(diff);
  assign acc_sum = 35'(sums[cmd.k]) + 35'(sq);

  always_ff @(posedge clk) begin
    if (cmd.acc_sq) begin
      sq <= mag * mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < TOPICS; i++) begin
        sums[i] <= '0;
      end
    end else if (cmd.acc_add) begin
      sums[cmd.k] <= (acc_sum[34:32] != 3'd0) ? 32'hFFFF_FFFF : acc_sum[31:0];
    end
  end

  // Minimum search over the sums, one topic a cycle.
  always_ff @(posedge clk) begin
    if (cmd.min_step) begin
      if (cmd.k == '0 || sums[cmd.k] < dmin) begin
        dmin <= sums[cmd.k];
      end
    end
  end

  // Exponential unit: one fraction bit a cycle, then the integer shift.
  assign gap       = sums[cmd.k] - dmin;
  assign y_full    = gap * HALF_LOG2E_Q16;
  assign t_prod    = t * ROOTS[cmd.step[3:0]];
  assign t_shifted = (y[31:16] > 16'd32) ? '0 : (t >> y[31:16]);

  always_ff @(posedge clk) begin
    if (cmd.exp_mul) begin
      y <= y_full[47:16];
      t <= TERM_W'(64'd1 << 32);
    end else if (cmd.exp_step && y[5'(FRAC_BITS - 1) - cmd.step]) begin
      t <= t_prod[64:32];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.min_step && cmd.k == '0) begin
      total <= '0;
    end else if (cmd.exp_sh) begin
      terms[cmd.k] <= t_shifted;
      total        <= total + TOTAL_W'(t_shifted);
    end
  end

  // Restoring divider, one quotient bit a cycle.
  assign num    = {terms[cmd.k], 16'd0} + 49'(total >> 1);
  assign rem_sh = {rem[TOTAL_W-1:0], num_lo[QW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem    <= (TOTAL_W + 1)'(num >> QW);
      num_lo <= num[QW-1:0];
      quo    <= '0;
    end else if (cmd.div_step) begin
      num_lo <= num_lo << 1;
      if (rem_sh >= (TOTAL_W + 1)'(total)) begin
        rem <= rem_sh - (TOTAL_W + 1)'(total);
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[QW-2:0], 1'b0};
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.div_out;
    end
    if (cmd.div_out) begin
      result.topic_out <= 4'(cmd.k);
      result.prob      <= quo[QW-1] ? 16'hFFFF : quo[15:0];
      result.last_out  <= (cmd.k == KW'(TOPICS - 1));
    end
  end

endmodule

@@ hdl/dstp_checker.sv @@
// ----------------------------------------------------------------------------
// Distance softmax checker
// Port-level properties of the core, bound to the top level.
// ----------------------------------------------------------------------------
module dstp_props (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input dstp_pkg::item_t   item,
  input logic              busy,
  input logic              strobe,
  input dstp_pkg::result_t result
);
  import dstp_pkg::*;

  // Results other than the final one appear while a document is being finished.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last_out) |-> busy)
    else $error("result strobe while idle");

  // Results are spaced by the divider, never back to back.
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("back to back results");

  // The final result carries the last topic.
  a_last_topic: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last_out) |-> (result.topic_out == 4'(TOPICS - 1)))
    else $error("last mark on wrong topic");

  // The block is already free while the final result is shown.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last_out) |-> !busy)
    else $error("still busy at last result");

  // A load item never makes the block busy.
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.command == CMD_LOAD) |=> !busy)
    else $error("busy after load item");

endmodule

bind distance_softmax_topic_probs_core dstp_props u_dstp_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .item   (item),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

@@ sim/dstp_checker.sv @@
// ----------------------------------------------------------------------------
// Distance softmax checker
// Watches accepted items and results, predicts topic probabilities from its
// own copy of the location table and distance sums, and counts mismatches.
// ----------------------------------------------------------------------------
module dstp_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  dstp_pkg::item_t   item,
  input  logic              strobe,
  input  dstp_pkg::result_t result,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import dstp_pkg::*;

  logic [15:0] loc_table [TOPICS*DIMS];
  logic [31:0] dist_sum [TOPICS];
  logic [31:0] two_roots [FRAC_BITS];
  result_t     expected_probs [$];

  // Floor square root, bit by bit.
  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    b = 64'd1 << 62;
    while (b > v && b != 0) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Approximates 2^32 * exp(-gap/2) with the fractional root table.
  function automatic logic [63:0] exp_weight(input logic [31:0] gap);
    logic [63:0] y;
    logic [63:0] whole;
    logic [63:0] t;
    y = (64'(gap) * 64'd47274) >> 16;
    whole = y >> 16;
    t = 64'd1 << 32;
    if (whole > 32) return 64'd0;
    for (int i = 0; i < FRAC_BITS; i++)
      if (y[15-i]) t = (t * 64'(two_roots[i])) >> 32;
    return t >> whole;
  endfunction

  // Accumulates one coordinate and, on last, queues the probabilities.
  task automatic predict_doc(input item_t it);
    logic signed [17:0] d;
    logic [63:0]        s;
    logic [31:0]        dmin;
    logic [63:0]        w [TOPICS];
    logic [63:0]        total;
    logic [63:0]        p;
    result_t            r;
    if (int'(it.dim) < DIMS) begin
      for (int k = 0; k < TOPICS; k++) begin
        d = 18'(it.coord) - 18'($signed(loc_table[k*DIMS + int'(it.dim)]));
        if (d < 0) d = -d;
        s = 64'(dist_sum[k]) + 64'(d) * 64'(d);
        dist_sum[k] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
      end
    end
    if (!it.last) return;
    dmin = dist_sum[0];
    for (int k = 1; k < TOPICS; k++) if (dist_sum[k] < dmin) dmin = dist_sum[k];
    total = 0;
    for (int k = 0; k < TOPICS; k++) begin
      w[k] = exp_weight(dist_sum[k] - dmin);
      total += w[k];
    end
    for (int k = 0; k < TOPICS; k++) begin
      p = ((w[k] << 16) + (total >> 1)) / total;
      r.topic_out = 4'(k);
      r.prob = (p > 65535) ? 16'hFFFF : p[15:0];
      r.last_out = (k == TOPICS - 1);
      expected_probs.push_back(r);
      dist_sum[k] = '0;
    end
  endtask

  initial begin
    logic [63:0] r;
    r = isqrt64(64'd1 << 63);
    two_roots[0] = r[31:0];
    for (int i = 1; i < FRAC_BITS; i++) begin
      r = isqrt64(r << 32);
      two_roots[i] = r[31:0];
    end
    foreach (loc_table[i]) loc_table[i] = '0;
    foreach (dist_sum[i]) dist_sum[i] = '0;
  end

  assign pending = expected_probs.size();

  // Prediction on accepted items and comparison on strobed results.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (start && !busy) begin
        if (item.command == CMD_LOAD) begin
          if (int'(item.topic) < TOPICS && int'(item.dim) < DIMS)
            loc_table[int'(item.topic)*DIMS + int'(item.dim)] = item.coord;
        end else begin
          predict_doc(item);
        end
      end
      if (strobe) begin
        if (expected_probs.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result %p", result);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_probs.pop_front();
          if (want !== result) begin
            if (fail_count < 10)
              $display("Mismatch: expected %p, got %p", want, result);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ sim/tb_distance_softmax_topic_probs_core.sv @@
// ----------------------------------------------------------------------------
// Distance softmax core testbench
// Loads topic locations, sends documents with directed and random
// coordinates in bursts, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_distance_softmax_topic_probs_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dstp_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    strobe;
  result_t result;
  int      fail_count;
  int      pending;
  int      burst_left = 0;
  longint  cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  distance_softmax_topic_probs_core u_top (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .strobe(strobe), .result(result)
  );

  dstp_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .strobe(strobe), .result(result), .fail_count(fail_count), .pending(pending)
  );

  // Cycle limit: a run that does not finish in time is failed.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3_000_000) begin
      $display("FAIL distance_softmax_topic_probs_core");
      $finish;
    end
  end

  // Sends one item; gaps come between random bursts, start stays high inside one.
  task automatic send_item(input logic cmd, input logic [3:0] tp, input logic d,
                           input logic [15:0] c, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    item <= '{command: cmd, topic: tp, dim: d, coord: c, last: lst};
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'h8000 | 16'($urandom_range(0, 3));
      1: return 16'h7FFF - 16'($urandom_range(0, 3));
      2: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    int items_sent;
    int n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fill every location, extremes included, load with last.
    for (int k = 0; k < TOPICS; k++)
      for (int d = 0; d < DIMS; d++)
        send_item(CMD_LOAD, 4'(k), 1'(d),
                  (k == 0) ? 16'h8000 : (k == 1) ? 16'h7FFF : 16'(k * 300 - d * 77),
                  1'(k == 3));
    // Extreme coordinates, repeated dim, single-coordinate document.
    send_item(CMD_DOC, 4'hF, 1'b0, 16'h7FFF, 1'b0);
    send_item(CMD_DOC, 4'h0, 1'b0, 16'h7FFF, 1'b0);
    send_item(CMD_DOC, 4'h5, 1'b1, 16'h8000, 1'b1);
    send_item(CMD_DOC, 4'h0, 1'b1, 16'h0000, 1'b1);
    send_item(CMD_DOC, 4'h0, 1'b0, 16'h0120, 1'b0);
    send_item(CMD_DOC, 4'h0, 1'b1, 16'hFF00, 1'b1);
    items_sent = 0;

    // Random: mostly well-formed documents, some reloads.
    while (items_sent < 400) begin
      if ($urandom_range(0, 5) == 0) begin
        send_item(CMD_LOAD, 4'($urandom()), 1'($urandom()), rand_coord(),
                  1'($urandom()));
        items_sent++;
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          send_item(CMD_DOC, 4'($urandom()),
                    (n == 2) ? 1'(i) : 1'($urandom()), rand_coord(),
                    1'(i == n - 1));
          items_sent++;
        end
      end
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (700) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS distance_softmax_topic_probs_core");
    end else begin
      $display("FAIL distance_softmax_topic_probs_core");
    end
    $finish;
  end
endmodule
